@@ rtl/bplb_pkg.sv @@
// Shared types and codes for the battery / power LED blink policy block.
// No dependencies; used by the config registers, policy logic and top level.
`timescale 1ns / 1ps

package bplb_pkg;

    // Item action codes
    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_BAT_WRITE = 2'd1;
    localparam logic [1:0] ACT_PWR_WRITE = 2'd2;

    // Chipset state codes
    localparam logic [1:0] CHIP_OFF     = 2'd0;
    localparam logic [1:0] CHIP_ON      = 2'd1;
    localparam logic [1:0] CHIP_SUSPEND = 2'd2;
    localparam logic [1:0] CHIP_OTHER   = 2'd3;

    // Charge state codes
    localparam logic [2:0] CHG_CHARGE    = 3'd0;
    localparam logic [2:0] CHG_DISCHARGE = 3'd1;
    localparam logic [2:0] CHG_ERROR     = 3'd2;
    localparam logic [2:0] CHG_NEAR_FULL = 3'd3;
    localparam logic [2:0] CHG_IDLE      = 3'd4;
    localparam logic [2:0] CHG_OTHER     = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_POWER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_BATTERY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAT_ACT_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWR_ACT_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWR_EXTERNAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_PERCENT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PERCENT   = 3'd6;

    localparam int unsigned PCT_W = 7;
    localparam logic [PCT_W-1:0] CRIT_PERCENT_RST = 7'd3;
    localparam logic [PCT_W-1:0] LOW_PERCENT_RST  = 7'd10;

    // Configuration as seen by the policy logic
    typedef struct packed {
        logic             auto_power;
        logic             auto_battery;
        logic             bat_active_low;
        logic             pwr_active_low;
        logic             pwr_external;
        logic [PCT_W-1:0] crit_percent;
        logic [PCT_W-1:0] low_percent;
    } t_cfg;

    // One registered input item
    typedef struct packed {
        logic [1:0]       action;
        logic [1:0]       chipset_state;
        logic [2:0]       chg_state;
        logic [PCT_W-1:0] charge_percent;
        logic             force_idle;
        logic             lid_open;
        logic             red_on;
        logic             green_on;
        logic             power_on;
    } t_item;

    // LED state: phase counters and pin levels (after polarity)
    typedef struct packed {
        logic [1:0] power_phase;
        logic [1:0] battery_phase;
        logic       red_level;
        logic       green_level;
        logic       power_level;
    } t_led_state;

endpackage

@@ rtl/battery_power_led_blink_policy_core.sv @@
// Top level of the battery / power LED blink policy block: input register,
// LED state register (which is also the result register) and assertions.
// Depends on bplb_pkg, bplb_cfg_regs and bplb_policy.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   action, chipset, charge, percent, flags
//  result    out        o_out_valid / i_out_ready bat_red_pin, bat_green_pin, power_pin
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  An item is registered in the input register on acceptance and its result in the LED state register;
//  one item per cycle is sustained while results are taken, set by the single policy stage.
//  Reset clears the phases, puts all pins at the off level and loads register defaults.
//  A stalled result holds the policy stage; the input register still takes one
//  item, so input ready only drops when both stages are full.

module battery_power_led_blink_policy_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [1:0]                     i_chipset_state,
    input  logic [2:0]                     i_chg_state,
    input  logic [bplb_pkg::PCT_W-1:0]     i_charge_percent,
    input  logic                           i_force_idle,
    input  logic                           i_lid_open,
    input  logic                           i_red_on,
    input  logic                           i_green_on,
    input  logic                           i_power_on,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_bat_red_pin,
    output logic                           o_bat_green_pin,
    output logic                           o_power_pin,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bplb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bplb_pkg::PCT_W-1:0]     i_cfg_data
);

    bplb_pkg::t_cfg       w_cfg;
    bplb_pkg::t_item      r_item;
    bplb_pkg::t_led_state r_state;
    bplb_pkg::t_led_state n_state;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 w_advance;

    bplb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bplb_policy u_policy (
        .i_cfg   (w_cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state)
    );

    // Pipeline control: the policy stage moves when it holds an item and the result slot is free or being taken
    assign w_advance  = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.action         <= i_action;
            r_item.chipset_state  <= i_chipset_state;
            r_item.chg_state      <= i_chg_state;
            r_item.charge_percent <= i_charge_percent;
            r_item.force_idle     <= i_force_idle;
            r_item.lid_open       <= i_lid_open;
            r_item.red_on         <= i_red_on;
            r_item.green_on       <= i_green_on;
            r_item.power_on       <= i_power_on;
        end
    end

    // LED state; its pin levels are the result of the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bat_red_pin   = r_state.red_level;
    assign o_bat_green_pin = r_state.green_level;
    assign o_power_pin     = r_state.power_level;

    // Manual writes never move the phase counters
    a_manual_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_item.action != bplb_pkg::ACT_TICK)
        |=> ($stable(r_state.power_phase) && $stable(r_state.battery_phase)))
        else $error("phase changed on a non-tick item");

    // Power LED under manual control keeps its phase on ticks
    a_manual_power_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_cfg.auto_power) |=> $stable(r_state.power_phase))
        else $error("power phase moved with automatic control off");

    // A processed item always leaves a result waiting
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result lost after policy stage");

    // State only changes when an item moves through the policy stage
    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("LED state changed without an item");

endmodule

@@ rtl/bplb_cfg_regs.sv @@
// Configuration register file for the LED blink policy block.
// Depends on bplb_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module bplb_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bplb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bplb_pkg::PCT_W-1:0]     i_cfg_data,
    output bplb_pkg::t_cfg                 o_cfg
);

    bplb_pkg::t_cfg r_cfg;
    bplb_pkg::t_cfg n_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register decode; unknown indexes are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bplb_pkg::REG_AUTO_POWER:   n_cfg.auto_power     = i_cfg_data[0];
                bplb_pkg::REG_AUTO_BATTERY: n_cfg.auto_battery   = i_cfg_data[0];
                bplb_pkg::REG_BAT_ACT_LOW:  n_cfg.bat_active_low = i_cfg_data[0];
                bplb_pkg::REG_PWR_ACT_LOW:  n_cfg.pwr_active_low = i_cfg_data[0];
                bplb_pkg::REG_PWR_EXTERNAL: n_cfg.pwr_external   = i_cfg_data[0];
                bplb_pkg::REG_CRIT_PERCENT: n_cfg.crit_percent   = i_cfg_data;
                bplb_pkg::REG_LOW_PERCENT:  n_cfg.low_percent    = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_power     <= 1'b1;
            r_cfg.auto_battery   <= 1'b1;
            r_cfg.bat_active_low <= 1'b0;
            r_cfg.pwr_active_low <= 1'b0;
            r_cfg.pwr_external   <= 1'b0;
            r_cfg.crit_percent   <= bplb_pkg::CRIT_PERCENT_RST;
            r_cfg.low_percent    <= bplb_pkg::LOW_PERCENT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/bplb_policy.sv @@
// Next-state logic of the LED policy: phase advance, colour choice and polarity.
// Depends on bplb_pkg for codes and the t_cfg, t_item and t_led_state types.
`timescale 1ns / 1ps

module bplb_policy (
    input  bplb_pkg::t_cfg       i_cfg,
    input  bplb_pkg::t_item      i_item,
    input  bplb_pkg::t_led_state i_state,
    output bplb_pkg::t_led_state o_state
);

    logic       w_tick;
    logic       w_shown;
    logic [1:0] w_pwr_phase;
    logic [1:0] w_bat_phase;
    logic       w_bat_amber_crit;
    logic       w_bat_amber_low;

    assign w_tick      = (i_item.action == bplb_pkg::ACT_TICK);
    assign w_shown     = i_cfg.pwr_external | i_item.lid_open;
    assign w_pwr_phase = i_state.power_phase + 2'd1;
    assign w_bat_phase = i_state.battery_phase + 2'd1;

    // Blink lit conditions, from the advanced phase
    assign w_bat_amber_crit = ~w_bat_phase[0];
    assign w_bat_amber_low  = (w_bat_phase == 2'd0);

    always_comb begin
        o_state = i_state;

        // Power LED
        if (w_tick && i_cfg.auto_power) begin
            o_state.power_phase = w_pwr_phase;
            case (i_item.chipset_state)
                bplb_pkg::CHIP_OFF:
                    o_state.power_level = i_cfg.pwr_active_low;
                bplb_pkg::CHIP_ON:
                    o_state.power_level = w_shown ^ i_cfg.pwr_active_low;
                bplb_pkg::CHIP_SUSPEND:
                    o_state.power_level = ((w_pwr_phase == 2'd0) & w_shown)
                                          ^ i_cfg.pwr_active_low;
                default: ;  // transitional: hold the pin
            endcase
        end else if (i_item.action == bplb_pkg::ACT_PWR_WRITE) begin
            o_state.power_level = i_item.power_on ^ i_cfg.pwr_active_low;
        end

        // Battery LED
        if (w_tick && i_cfg.auto_battery) begin
            o_state.battery_phase = w_bat_phase;
            case (i_item.chg_state)
                bplb_pkg::CHG_CHARGE: begin
                    o_state.red_level   = ~i_cfg.bat_active_low;
                    o_state.green_level = ~i_cfg.bat_active_low;
                end
                bplb_pkg::CHG_DISCHARGE: begin
                    if (i_item.charge_percent < i_cfg.crit_percent) begin
                        o_state.red_level   = w_bat_amber_crit ^ i_cfg.bat_active_low;
                        o_state.green_level = w_bat_amber_crit ^ i_cfg.bat_active_low;
                    end else if (i_item.charge_percent < i_cfg.low_percent) begin
                        o_state.red_level   = w_bat_amber_low ^ i_cfg.bat_active_low;
                        o_state.green_level = w_bat_amber_low ^ i_cfg.bat_active_low;
                    end else begin
                        o_state.red_level   = i_cfg.bat_active_low;
                        o_state.green_level = i_cfg.bat_active_low;
                    end
                end
                bplb_pkg::CHG_ERROR: begin
                    o_state.red_level   = w_bat_amber_crit ^ i_cfg.bat_active_low;
                    o_state.green_level = i_cfg.bat_active_low;
                end
                bplb_pkg::CHG_NEAR_FULL: begin
                    o_state.red_level   = i_cfg.bat_active_low;
                    o_state.green_level = ~i_cfg.bat_active_low;
                end
                bplb_pkg::CHG_IDLE: begin
                    // forced idle alternates amber and green with the battery phase
                    o_state.red_level   = (i_item.force_idle & ~w_bat_phase[1])
                                          ^ i_cfg.bat_active_low;
                    o_state.green_level = ~i_cfg.bat_active_low;
                end
                default: ;  // other charge states: hold the pins
            endcase
        end else if (i_item.action == bplb_pkg::ACT_BAT_WRITE) begin
            o_state.red_level   = i_item.red_on   ^ i_cfg.bat_active_low;
            o_state.green_level = i_item.green_on ^ i_cfg.bat_active_low;
        end
    end

endmodule
